[sv/rle8_row_encoder_macros.svh]
// Assertion macros shared by the RLE8 row encoder modules.
`ifndef RLE8_ROW_ENCODER_MACROS_SVH
`define RLE8_ROW_ENCODER_MACROS_SVH

`ifndef SYNTHESIS

`define RLE8_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define RLE8_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define RLE8_ASSERT_IMP(lbl, ante, cons, msg)

`define RLE8_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

[sv/rle8_pkg.sv]
// Types and constants shared by the RLE8 row encoder modules.
`timescale 1ns / 1ps

package rle8_pkg;

  localparam int LIT_CNT_W = 6;
  localparam int CMD_DEPTH = 2;
  localparam int CMD_PTR_W = 1;
  localparam int CMD_CNT_W = 2;

  localparam logic [7:0] BYTE_ZERO = 8'h00;
  localparam logic [7:0] BYTE_ONE  = 8'h01;
  localparam logic [7:0] BYTE_EOI  = 8'h01;

  typedef struct packed {
    logic                 run_first;
    logic                 run_en;
    logic [7:0]           run_cnt;
    logic [7:0]           run_val;
    logic [LIT_CNT_W-1:0] mem_cnt;
    logic                 tail_en;
    logic [7:0]           tail_val;
    logic                 bank;
    logic                 eol;
    logic                 eoi;
  } cmd_t;

  typedef struct packed {
    logic                 en;
    logic                 bank;
    logic [LIT_CNT_W-1:0] idx;
    logic [7:0]           data;
  } lit_wr_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } bank_rel_t;

endpackage

[sv/rle8_if.sv]
// Valid/ready channel interfaces for pixels in and encoded bytes out.
`timescale 1ns / 1ps

interface rle8_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel;
  logic       last_in_row;
  logic       last_in_image;

  modport source (output valid, output pixel, output last_in_row, output last_in_image,
                  input ready);
  modport sink (input valid, input pixel, input last_in_row, input last_in_image,
                output ready);
endinterface

interface rle8_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_byte;

  modport source (output valid, output out_byte, output last_byte, input ready);
  modport sink (input valid, input out_byte, input last_byte, output ready);
endinterface

[sv/rle8_row_encoder.sv]
// RLE8 row encoder top level.
// in_pix carries one 8-bit palette index per request with last_in_row and
// last_in_image; out_bytes carries the encoded stream one byte per request,
// last_byte set on the final byte caused by a pixel. Both use valid/ready.
// The front end takes a pixel whenever the two-entry command queue has room
// and the literal bank it fills is free; a pixel that only extends a run
// produces no bytes. In its idle state the sequencer loads a command from
// the queue, then emits its bytes through the output register. The
// sequencer's byte-per-cycle output while the receiver is ready, with an
// idle load step per command, sets the sustained rate. Literals live in a
// two-bank memory, so one group can be sent while the next is gathered.
// Reset clears run, literal and row state, the queue and the output stage;
// literal memory contents are not cleared and need no sweep.
// When the receiver stalls, the output register holds, the sequencer stops,
// the queue fills and in_pix.ready drops.
`timescale 1ns / 1ps

module rle8_row_encoder #(
  parameter int MAX_RUN     = 255,
  parameter int MAX_LITERAL = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  rle8_pix_if.sink    in_pix,
  rle8_byte_if.source out_bytes
);
  import rle8_pkg::*;

  cmd_t      q_cmd;
  cmd_t      q_head;
  logic      q_push;
  logic      q_full;
  logic      q_pop;
  logic      q_empty;
  lit_wr_t   lit_wr;
  bank_rel_t bank_rel;

  rle8_front #(
    .MAX_RUN     (MAX_RUN),
    .MAX_LITERAL (MAX_LITERAL)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .pix      (in_pix),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_cmd),
    .lit_wr   (lit_wr),
    .bank_rel (bank_rel)
  );

  rle8_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  rle8_back #(
    .MAX_LITERAL (MAX_LITERAL)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (!q_empty),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .lit_wr   (lit_wr),
    .bank_rel (bank_rel),
    .obus     (out_bytes)
  );

endmodule

[sv/rle8_front.sv]
// Front end: takes pixels, tracks runs and literals, issues byte commands.
`timescale 1ns / 1ps
`include "rle8_row_encoder_macros.svh"

module rle8_front #(
  parameter int MAX_RUN     = 255,
  parameter int MAX_LITERAL = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  rle8_pix_if.sink            pix,
  input  logic                q_full,
  output logic                q_push,
  output rle8_pkg::cmd_t      q_cmd,
  output rle8_pkg::lit_wr_t   lit_wr,
  input  rle8_pkg::bank_rel_t bank_rel
);
  import rle8_pkg::*;

  localparam logic [7:0]           RUN_CAP   = 8'(MAX_RUN);
  localparam logic [LIT_CNT_W-1:0] LIT_LIMIT = LIT_CNT_W'(MAX_LITERAL - 1);

  logic [7:0]           run_value_r, run_value_nxt;
  logic [7:0]           run_len_r, run_len_nxt;
  logic [LIT_CNT_W-1:0] lit_len_r, lit_len_nxt;
  logic                 row_started_r, row_started_nxt;
  logic                 bank_r, bank_nxt;
  logic [1:0]           busy_r, busy_nxt;

  logic       ready;
  logic       accept;
  logic       eor;
  logic       eoi;
  logic       match;
  logic       flush;
  logic       wr_want;
  logic [7:0] rl1;

  assign ready     = !q_full && !busy_r[bank_r];
  assign pix.ready = ready;
  assign accept    = pix.valid && ready;

  always_comb begin
    eoi   = pix.last_in_image;
    eor   = pix.last_in_row | pix.last_in_image;
    match = row_started_r && (run_len_r != 8'd0) && (pix.pixel == run_value_r);
    rl1   = run_len_r + 8'd1;

    q_cmd       = '0;
    q_cmd.bank  = bank_r;
    flush       = 1'b0;
    wr_want     = 1'b0;

    run_value_nxt   = run_value_r;
    run_len_nxt     = run_len_r;
    lit_len_nxt     = lit_len_r;
    row_started_nxt = 1'b1;

    if (match) begin
      run_len_nxt = rl1;
      if (rl1 == 8'd2 && lit_len_r != '0) begin
        q_cmd.mem_cnt = lit_len_r;
        flush         = 1'b1;
        lit_len_nxt   = '0;
      end
      if (rl1 >= RUN_CAP) begin
        q_cmd.run_en  = 1'b1;
        q_cmd.run_cnt = rl1;
        q_cmd.run_val = run_value_r;
        run_len_nxt   = 8'd0;
      end else if (eor) begin
        q_cmd.run_en  = 1'b1;
        q_cmd.run_cnt = rl1;
        q_cmd.run_val = run_value_r;
      end
    end else begin
      if (run_len_r >= 8'd2) begin
        q_cmd.run_en    = 1'b1;
        q_cmd.run_first = 1'b1;
        q_cmd.run_cnt   = run_len_r;
        q_cmd.run_val   = run_value_r;
      end else if (run_len_r == 8'd1) begin
        wr_want     = 1'b1;
        lit_len_nxt = lit_len_r + LIT_CNT_W'(1);
        if (!eor && lit_len_nxt >= LIT_LIMIT) begin
          q_cmd.mem_cnt = lit_len_nxt;
          flush         = 1'b1;
          lit_len_nxt   = '0;
        end
      end
      run_value_nxt = pix.pixel;
      run_len_nxt   = 8'd1;
      if (eor) begin
        q_cmd.tail_en  = 1'b1;
        q_cmd.tail_val = pix.pixel;
        q_cmd.mem_cnt  = lit_len_nxt;
        flush          = (lit_len_nxt != '0);
      end
    end

    if (eor) begin
      q_cmd.eol       = 1'b1;
      q_cmd.eoi       = eoi;
      run_len_nxt     = 8'd0;
      lit_len_nxt     = '0;
      row_started_nxt = 1'b0;
    end

    lit_wr.en   = accept && wr_want;
    lit_wr.bank = bank_r;
    lit_wr.idx  = lit_len_r;
    lit_wr.data = run_value_r;

    q_push = accept && (q_cmd.run_en || (q_cmd.mem_cnt != '0) || q_cmd.tail_en || q_cmd.eol);

    busy_nxt = busy_r;
    if (bank_rel.valid) begin
      busy_nxt[bank_rel.bank] = 1'b0;
    end
    if (accept && flush) begin
      busy_nxt[bank_r] = 1'b1;
    end
    bank_nxt = bank_r ^ (accept && flush);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_value_r   <= 8'd0;
      run_len_r     <= 8'd0;
      lit_len_r     <= '0;
      row_started_r <= 1'b0;
      bank_r        <= 1'b0;
      busy_r        <= 2'b00;
    end else begin
      busy_r <= busy_nxt;
      bank_r <= bank_nxt;
      if (accept) begin
        run_value_r   <= run_value_nxt;
        run_len_r     <= run_len_nxt;
        lit_len_r     <= lit_len_nxt;
        row_started_r <= row_started_nxt;
      end
    end
  end

  `RLE8_ASSERT_IMP(a_wr_free_bank, lit_wr.en, !busy_r[lit_wr.bank], "literal write into busy bank")
  `RLE8_ASSERT_IMP(a_lit_bound, 1'b1, lit_len_r < LIT_LIMIT, "literal count past limit")
  `RLE8_ASSERT_IMP(a_run_bound, 1'b1, run_len_r < RUN_CAP, "run count past cap")
  `RLE8_ASSERT_NXT(a_row_clear, accept && eor,
                   run_len_r == 8'd0 && lit_len_r == '0 && !row_started_r,
                   "row state not cleared at row end")

endmodule

[sv/rle8_cmd_fifo.sv]
// Two-entry command queue between the front end and the byte sequencer.
`timescale 1ns / 1ps

module rle8_cmd_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  rle8_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output rle8_pkg::cmd_t head,
  output logic           empty
);
  import rle8_pkg::*;

  cmd_t                 slots_r [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CMD_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CMD_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 do_push;
  logic                 do_pop;

  assign full    = (cnt_r == CMD_CNT_W'(CMD_DEPTH));
  assign empty   = (cnt_r == '0);
  assign head    = slots_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + CMD_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + CMD_PTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CMD_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CMD_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

[sv/rle8_back.sv]
// Byte sequencer: literal memory, command execution and output register.
`timescale 1ns / 1ps
`include "rle8_row_encoder_macros.svh"

module rle8_back #(
  parameter int MAX_LITERAL = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  rle8_pkg::cmd_t      q_head,
  output logic                q_pop,
  input  rle8_pkg::lit_wr_t   lit_wr,
  output rle8_pkg::bank_rel_t bank_rel,
  rle8_byte_if.source         obus
);
  import rle8_pkg::*;

  localparam int IDX_W     = $clog2(MAX_LITERAL);
  localparam int ADDR_W    = IDX_W + 1;
  localparam int MEM_DEPTH = 2 ** ADDR_W;

  typedef enum logic [3:0] {
    B_IDLE,
    B_RUN_CNT,
    B_RUN_VAL,
    B_LIT_ESC,
    B_LIT_CNT,
    B_LIT_DATA,
    B_LIT_PAD,
    B_ONE_CODE,
    B_ONE_VAL,
    B_EOL0,
    B_EOL1,
    B_EOI0,
    B_EOI1
  } bstate_t;

  function automatic bstate_t pick(input cmd_t c, input logic rp, input logic lp);
    logic [LIT_CNT_W-1:0] tot;
    bstate_t              s;
    tot = c.mem_cnt + LIT_CNT_W'(c.tail_en);
    if (c.run_first && rp) begin
      s = B_RUN_CNT;
    end else if (lp) begin
      s = (tot < LIT_CNT_W'(3)) ? B_ONE_CODE : B_LIT_ESC;
    end else if (rp) begin
      s = B_RUN_CNT;
    end else if (c.eol) begin
      s = B_EOL0;
    end else begin
      s = B_IDLE;
    end
    return s;
  endfunction

  bstate_t              state_r, state_nxt;
  cmd_t                 cmd_r, cmd_nxt;
  logic [LIT_CNT_W-1:0] k_r, k_nxt;
  logic                 rp_r, rp_nxt;
  logic                 lp_r, lp_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [7:0]           out_byte_r, out_byte_nxt;
  logic                 out_last_r, out_last_nxt;

  logic [7:0]           lit_mem [MEM_DEPTH];
  logic [7:0]           rd_data_r;
  logic [ADDR_W-1:0]    rd_addr;

  logic                 slot;
  logic                 emit;
  logic                 emit_last;
  logic [7:0]           emit_byte;
  logic [LIT_CNT_W-1:0] lit_total;
  logic [7:0]           lit_byte;

  assign slot      = !out_valid_r || obus.ready;
  assign lit_total = cmd_r.mem_cnt + LIT_CNT_W'(cmd_r.tail_en);
  assign lit_byte  = (k_r < cmd_r.mem_cnt) ? rd_data_r : cmd_r.tail_val;

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    k_nxt     = k_r;
    rp_nxt    = rp_r;
    lp_nxt    = lp_r;
    emit      = 1'b0;
    emit_byte = BYTE_ZERO;
    q_pop     = 1'b0;

    case (state_r)
      B_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          cmd_nxt   = q_head;
          rp_nxt    = q_head.run_en;
          lp_nxt    = (q_head.mem_cnt != '0) || q_head.tail_en;
          k_nxt     = '0;
          state_nxt = pick(q_head, q_head.run_en, (q_head.mem_cnt != '0) || q_head.tail_en);
        end
      end
      B_RUN_CNT: begin
        if (slot) begin
          emit      = 1'b1;
          emit_byte = cmd_r.run_cnt;
          state_nxt = B_RUN_VAL;
        end
      end
      B_RUN_VAL: begin
        if (slot) begin
          emit      = 1'b1;
          emit_byte = cmd_r.run_val;
          rp_nxt    = 1'b0;
          state_nxt = pick(cmd_r, 1'b0, lp_r);
        end
      end
      B_LIT_ESC: begin
        if (slot) begin
          emit      = 1'b1;
          emit_byte = BYTE_ZERO;
          state_nxt = B_LIT_CNT;
        end
      end
      B_LIT_CNT: begin
        if (slot) begin
          emit      = 1'b1;
          emit_byte = 8'(lit_total);
          k_nxt     = '0;
          state_nxt = B_LIT_DATA;
        end
      end
      B_LIT_DATA: begin
        if (slot) begin
          emit      = 1'b1;
          emit_byte = lit_byte;
          k_nxt     = k_r + LIT_CNT_W'(1);
          if (k_nxt == lit_total) begin
            if (lit_total[0]) begin
              state_nxt = B_LIT_PAD;
            end else begin
              lp_nxt    = 1'b0;
              state_nxt = pick(cmd_r, rp_r, 1'b0);
            end
          end
        end
      end
      B_LIT_PAD: begin
        if (slot) begin
          emit      = 1'b1;
          emit_byte = BYTE_ZERO;
          lp_nxt    = 1'b0;
          state_nxt = pick(cmd_r, rp_r, 1'b0);
        end
      end
      B_ONE_CODE: begin
        if (slot) begin
          emit      = 1'b1;
          emit_byte = BYTE_ONE;
          state_nxt = B_ONE_VAL;
        end
      end
      B_ONE_VAL: begin
        if (slot) begin
          emit      = 1'b1;
          emit_byte = lit_byte;
          k_nxt     = k_r + LIT_CNT_W'(1);
          if (k_nxt == lit_total) begin
            lp_nxt    = 1'b0;
            state_nxt = pick(cmd_r, rp_r, 1'b0);
          end else begin
            state_nxt = B_ONE_CODE;
          end
        end
      end
      B_EOL0: begin
        if (slot) begin
          emit      = 1'b1;
          emit_byte = BYTE_ZERO;
          state_nxt = B_EOL1;
        end
      end
      B_EOL1: begin
        if (slot) begin
          emit      = 1'b1;
          emit_byte = BYTE_ZERO;
          state_nxt = cmd_r.eoi ? B_EOI0 : B_IDLE;
        end
      end
      B_EOI0: begin
        if (slot) begin
          emit      = 1'b1;
          emit_byte = BYTE_ZERO;
          state_nxt = B_EOI1;
        end
      end
      B_EOI1: begin
        if (slot) begin
          emit      = 1'b1;
          emit_byte = BYTE_EOI;
          state_nxt = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase

    emit_last      = emit && (state_nxt == B_IDLE);
    bank_rel.valid = emit_last && (cmd_r.mem_cnt != '0);
    bank_rel.bank  = cmd_r.bank;

    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = emit_byte;
      out_last_nxt  = emit_last;
    end else if (obus.ready) begin
      out_valid_nxt = 1'b0;
    end

    rd_addr = {cmd_nxt.bank, k_nxt[IDX_W-1:0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      k_r         <= '0;
      rp_r        <= 1'b0;
      lp_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      rp_r        <= rp_nxt;
      lp_r        <= lp_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r      <= cmd_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (lit_wr.en) begin
      lit_mem[{lit_wr.bank, lit_wr.idx[IDX_W-1:0]}] <= lit_wr.data;
    end
    rd_data_r <= lit_mem[rd_addr];
  end

  assign obus.valid     = out_valid_r;
  assign obus.out_byte  = out_byte_r;
  assign obus.last_byte = out_last_r;

  `RLE8_ASSERT_IMP(a_data_in_group, state_r == B_LIT_DATA, k_r < lit_total,
                   "absolute index past group")
  `RLE8_ASSERT_IMP(a_short_group, state_r == B_ONE_VAL,
                   lit_total < LIT_CNT_W'(3) && lit_total != '0,
                   "short literal group out of range")
  `RLE8_ASSERT_IMP(a_pad_odd, state_r == B_LIT_PAD, lit_total[0],
                   "pad byte on even group")

endmodule
